// ----- rtl/qla_pkg.sv -----
package qla_pkg;

    localparam int MAX_DIM  = 128;
    localparam int DIM_W    = $clog2(MAX_DIM);
    localparam int DIMC_W   = DIM_W + 1;
    localparam int CELL_AW  = 2 * DIM_W;
    localparam int BANK_AW  = CELL_AW + 1;
    localparam int NCELLS   = MAX_DIM * MAX_DIM;
    localparam int CFG_W    = 8;
    localparam int CELL_W   = 3;
    localparam int POP_W    = 15;
    localparam int GEN_W    = 32;
    localparam int RESET_DIM = 100;

    localparam logic [DIMC_W-1:0] DIM_LAST = DIMC_W'(MAX_DIM);
    localparam logic [POP_W-1:0]  POP_MAX  = '1;
    localparam logic [CELL_W-1:0] COLOR_MAX = 3'd4;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_STEP  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_action             action;
        logic [DIM_W-1:0]    row;
        logic [DIM_W-1:0]    col;
        logic [CELL_W-1:0]   color;
    } t_in;

    typedef struct packed {
        logic [CELL_W-1:0]   cell_value;
        logic [POP_W-1:0]    population;
        logic [GEN_W-1:0]    generation;
    } t_out;

    // Port bundle of the board memory.
    typedef struct packed {
        logic                we;
        logic [BANK_AW-1:0]  waddr;
        logic [CELL_W-1:0]   wdata;
        logic [BANK_AW-1:0]  raddr;
    } t_mem_req;

    // Three vertically adjacent cells: index 0 top, 1 middle, 2 bottom.
    typedef logic [2:0][CELL_W-1:0] t_col;

    function automatic logic [DIMC_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
        logic [DIMC_W-1:0] res;
        if (r == '0) begin
            res = DIMC_W'(1);
        end else if (int'(r) > MAX_DIM) begin
            res = DIM_LAST;
        end else begin
            res = DIMC_W'(r);
        end
        return res;
    endfunction

    // Quad-Life rule for one cell given its eight neighbours.
    function automatic logic [CELL_W-1:0] next_cell(
        input logic [CELL_W-1:0]        cur,
        input logic [7:0][CELL_W-1:0]   nb
    );
        logic [3:0]        cnt [1:4];
        logic [3:0]        total;
        logic [CELL_W-1:0] best_c;
        logic [CELL_W-1:0] missing;
        logic [CELL_W-1:0] res;
        total   = '0;
        best_c  = '0;
        missing = 3'd1;
        for (int k = 1; k <= 4; k++) begin
            cnt[k] = '0;
            for (int i = 0; i < 8; i++) begin
                if (nb[i] == CELL_W'(k)) begin
                    cnt[k] = cnt[k] + 4'd1;
                end
            end
            total = total + cnt[k];
        end
        for (int k = 1; k <= 4; k++) begin
            if (cnt[k] >= 4'd2) begin
                best_c = CELL_W'(k);
            end
            if (k >= 2 && cnt[k] == '0) begin
                missing = CELL_W'(k);
            end
        end
        if (cur == '0) begin
            if (total == 4'd3) begin
                res = (best_c != '0) ? best_c : missing;
            end else begin
                res = '0;
            end
        end else begin
            res = (total == 4'd2 || total == 4'd3) ? cur : '0;
        end
        return res;
    endfunction

endpackage

// ----- rtl/qla_ram.sv -----
module qla_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/qla_gen.sv -----
module qla_gen (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_bank,
    input  logic [qla_pkg::DIMC_W-1:0]   i_nr,
    input  logic [qla_pkg::DIMC_W-1:0]   i_nc,
    input  logic [qla_pkg::CELL_W-1:0]   i_rdata,
    output qla_pkg::t_mem_req            o_req,
    output logic                         o_done,
    output logic [qla_pkg::POP_W-1:0]    o_pop
);
    import qla_pkg::*;

    // Read stage: raster position of the bottom row of the window.
    logic              r_run;
    logic [DIMC_W-1:0] r_s;
    logic [DIMC_W-1:0] r_j;
    // Data stage and compute stage tags.
    logic              r_b_v;
    logic [DIMC_W-1:0] r_b_s;
    logic [DIMC_W-1:0] r_b_j;
    logic              r_c_v;
    logic [DIMC_W-1:0] r_c_s;
    logic [DIMC_W-1:0] r_c_j;
    logic              r_done;
    logic [POP_W-1:0]  r_pop;
    t_col              r_wl;
    t_col              r_wm;
    t_col              r_wr;

    logic [CELL_W-1:0] lb0_rdata;
    logic [CELL_W-1:0] lb1_rdata;
    logic              lb_we;
    t_col              new_col;
    logic              col_ok;
    logic [DIMC_W-1:0] c_row;
    logic [DIMC_W-1:0] c_colm;
    logic              c_write;
    logic              c_inside;
    logic [CELL_W-1:0] c_val;
    logic [7:0][CELL_W-1:0] nb;

    // Line buffers: lb0 holds the row above the bottom row, lb1 the one above that.
    qla_ram #(.WIDTH(CELL_W), .DEPTH(MAX_DIM)) u_lb0 (
        .i_clk   (i_clk),
        .i_we    (lb_we),
        .i_waddr (r_b_j[DIM_W-1:0]),
        .i_wdata (new_col[2]),
        .i_raddr (r_j[DIM_W-1:0]),
        .o_rdata (lb0_rdata)
    );

    qla_ram #(.WIDTH(CELL_W), .DEPTH(MAX_DIM)) u_lb1 (
        .i_clk   (i_clk),
        .i_we    (lb_we),
        .i_waddr (r_b_j[DIM_W-1:0]),
        .i_wdata (new_col[1]),
        .i_raddr (r_j[DIM_W-1:0]),
        .o_rdata (lb1_rdata)
    );

    assign lb_we = r_b_v && (r_b_j != DIM_LAST);

    // Cells outside the region in use read as dead.
    always_comb begin
        col_ok     = r_b_j < i_nc;
        new_col[2] = (col_ok && r_b_s < i_nr) ? i_rdata : '0;
        new_col[1] = (col_ok && r_b_s != '0 && (r_b_s - DIMC_W'(1)) < i_nr)
                     ? lb0_rdata : '0;
        new_col[0] = (col_ok && r_b_s > DIMC_W'(1) && (r_b_s - DIMC_W'(2)) < i_nr)
                     ? lb1_rdata : '0;
    end

    always_comb begin
        nb       = {r_wl[0], r_wl[1], r_wl[2], r_wm[0], r_wm[2], r_wr[0], r_wr[1], r_wr[2]};
        c_row    = r_c_s - DIMC_W'(1);
        c_colm   = r_c_j - DIMC_W'(1);
        c_write  = r_c_v && r_c_s != '0 && r_c_j != '0;
        c_inside = (c_row < i_nr) && (c_colm < i_nc);
        c_val    = c_inside ? next_cell(r_wm[1], nb) : '0;
    end

    always_comb begin
        o_req.raddr = {i_bank, r_s[DIM_W-1:0], r_j[DIM_W-1:0]};
        o_req.we    = c_write;
        o_req.waddr = {~i_bank, c_row[DIM_W-1:0], c_colm[DIM_W-1:0]};
        o_req.wdata = c_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_b_v  <= 1'b0;
            r_c_v  <= 1'b0;
            r_done <= 1'b0;
            r_s    <= '0;
            r_j    <= '0;
            r_pop  <= '0;
        end else begin
            r_b_v  <= r_run;
            r_c_v  <= r_b_v;
            r_done <= r_c_v && r_c_s == DIM_LAST && r_c_j == DIM_LAST;
            if (i_start) begin
                r_run <= 1'b1;
                r_s   <= '0;
                r_j   <= '0;
                r_pop <= '0;
            end else begin
                if (r_run) begin
                    if (r_j == DIM_LAST) begin
                        r_j <= '0;
                        if (r_s == DIM_LAST) begin
                            r_run <= 1'b0;
                        end else begin
                            r_s <= r_s + DIMC_W'(1);
                        end
                    end else begin
                        r_j <= r_j + DIMC_W'(1);
                    end
                end
                if (c_write && c_val != '0 && r_pop != POP_MAX) begin
                    r_pop <= r_pop + POP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_s <= r_s;
        r_b_j <= r_j;
        r_c_s <= r_b_s;
        r_c_j <= r_b_j;
        if (r_b_v) begin
            if (r_b_j == '0) begin
                r_wl <= '0;
                r_wm <= '0;
            end else begin
                r_wl <= r_wm;
                r_wm <= r_wr;
            end
            r_wr <= new_col;
        end
    end

    assign o_done = r_done;
    assign o_pop  = r_pop;

endmodule

// ----- rtl/quad_life_automaton_top.sv -----
// Four-colour Life engine on a bounded board of up to 128 x 128 cells, held in one
// synchronous memory split into two banks that swap roles on every generation. Each
// accepted word gives one result word carrying the read value, the population and the
// generation count. A write passes from acceptance through the finish state to the
// result and a read through the read-wait and finish states. A clear sweeps all
// 16384 cells of the active bank at one cell per cycle. A generation streams the whole
// 128 x 128 board through a 3 x 3 window fed by the board memory and two line-buffer
// memories, one cell per cycle, with one extra row and column to flush the window.
// After reset the block first sweeps the active bank to dead, during which no input
// word is taken; configuration writes are taken at any time. Rows and columns of zero
// count as one and values above 128 count as 128.
module quad_life_automaton_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [qla_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  qla_pkg::t_in                i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output qla_pkg::t_out               o_out
);
    import qla_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_RDWAIT = 5'b00010,
        ST_STEP   = 5'b00100,
        ST_CLEAR  = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CFG_W-1:0]   r_rows;
    logic [CFG_W-1:0]   r_cols;
    logic               r_bank;
    logic               r_init;
    logic [CELL_AW-1:0] r_clr;
    logic [POP_W-1:0]   r_live;
    logic [GEN_W-1:0]   r_gen;
    t_in                r_item;
    logic [CELL_W-1:0]  r_cell;
    logic               r_out_valid;
    t_out               r_out;

    logic [DIMC_W-1:0]  nr;
    logic [DIMC_W-1:0]  nc;
    logic               accept;
    logic               in_inside;
    logic               item_inside;
    logic               out_free;
    t_mem_req           mem;
    t_mem_req           gen_req;
    logic               gen_start;
    logic               gen_done;
    logic [POP_W-1:0]   gen_pop;
    logic [CELL_W-1:0]  rdata;

    assign nr          = eff_dim(r_rows);
    assign nc          = eff_dim(r_cols);
    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign in_inside   = (DIMC_W'(i_in.row) < nr) && (DIMC_W'(i_in.col) < nc);
    assign item_inside = (DIMC_W'(r_item.row) < nr) && (DIMC_W'(r_item.col) < nc);
    assign out_free    = !r_out_valid || i_out_ready;
    assign gen_start   = accept && i_in.action == ACT_STEP;

    // The two banks: the active one holds the board, the other receives the next one.
    qla_ram #(.WIDTH(CELL_W), .DEPTH(2 * NCELLS)) u_board (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    qla_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gen_start),
        .i_bank  (r_bank),
        .i_nr    (nr),
        .i_nc    (nc),
        .i_rdata (rdata),
        .o_req   (gen_req),
        .o_done  (gen_done),
        .o_pop   (gen_pop)
    );

    // Board port arbitration: single cell accesses in idle, the sweeps in step and clear.
    always_comb begin
        mem = '0;
        unique case (r_state)
            ST_IDLE: begin
                mem.raddr = {r_bank, i_in.row, i_in.col};
                mem.waddr = {r_bank, i_in.row, i_in.col};
                mem.wdata = i_in.color;
                mem.we    = accept && i_in.action == ACT_WRITE && in_inside
                            && i_in.color <= COLOR_MAX;
            end
            ST_STEP: begin
                mem = gen_req;
            end
            ST_CLEAR: begin
                mem.we    = 1'b1;
                mem.waddr = {r_bank, r_clr};
                mem.wdata = '0;
            end
            default: begin
                mem = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_in.action)
                        ACT_WRITE: n_state = ST_FINISH;
                        ACT_READ:  n_state = ST_RDWAIT;
                        ACT_STEP:  n_state = ST_STEP;
                        ACT_CLEAR: n_state = ST_CLEAR;
                        default:   n_state = ST_FINISH;
                    endcase
                end
            end
            ST_RDWAIT: n_state = ST_FINISH;
            ST_STEP: begin
                if (gen_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = r_init ? ST_IDLE : ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_init      <= 1'b1;
            r_clr       <= '0;
            r_bank      <= 1'b0;
            r_rows      <= CFG_W'(RESET_DIM);
            r_cols      <= CFG_W'(RESET_DIM);
            r_live      <= '0;
            r_gen       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_ROWS: r_rows <= i_cfg_data;
                    CFG_COLS: r_cols <= i_cfg_data;
                    default:  r_rows <= r_rows;
                endcase
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + CELL_AW'(1);
                if (r_clr == '1) begin
                    r_init <= 1'b0;
                end
            end
            if (accept && i_in.action == ACT_CLEAR) begin
                r_live <= '0;
                r_gen  <= '0;
            end
            if (r_state == ST_STEP && gen_done) begin
                r_bank <= ~r_bank;
                r_live <= gen_pop;
                r_gen  <= r_gen + GEN_W'(1);
            end
            if (r_state == ST_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Word payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in;
            r_cell <= '0;
        end
        if (r_state == ST_RDWAIT) begin
            r_cell <= item_inside ? rdata : '0;
        end
        if (r_state == ST_FINISH && out_free) begin
            r_out.cell_value <= r_cell;
            r_out.population <= r_live;
            r_out.generation <= r_gen;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
